FILE: sv/mbei_pkg.sv
// Shared types, constants and helpers of the multicarrier burst error injector.
package mbei_pkg;

	localparam int MAX_CARRIERS = 16;
	localparam int CIDX_W       = $clog2(MAX_CARRIERS);
	localparam int CNUM_W       = CIDX_W + 1;
	localparam int FRAME_W      = 17;
	localparam int REG_W        = 16;
	localparam int START_W      = REG_W + CNUM_W;
	localparam int END_W        = START_W + 1;
	localparam int MAX_GROUP    = 9;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QFILL_W      = QPTR_W + 1;
	localparam int CFG_IDX_W    = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CARRIERS = 3'd0,
		CFG_GROUP    = 3'd1,
		CFG_PERIOD   = 3'd2,
		CFG_LENGTH   = 3'd3,
		CFG_OFFSET   = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_CLEAR = 2'd0,
		PH_BURST = 2'd1,
		PH_DONE  = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PHASE,
		ST_BIT,
		ST_DONE
	} eng_state_t;

	typedef struct packed {
		logic [4:0]       carriers_in_use;
		logic [3:0]       group_bits;
		logic [REG_W-1:0] burst_period_frames;
		logic [REG_W-1:0] burst_length_frames;
		logic [REG_W-1:0] burst_offset_frames;
	} cfg_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic [7:0] noise_mask;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [3:0] flipped_bits;
		logic       last;
	} out_item_t;

	// A carrier count of zero acts as one, above the maximum as the maximum
	function automatic logic [CNUM_W-1:0] eff_carriers(input logic [4:0] n);
		logic [CNUM_W-1:0] r;
		if (n == 5'd0) begin
			r = CNUM_W'(1);
		end else if (32'(n) > MAX_CARRIERS) begin
			r = CNUM_W'(MAX_CARRIERS);
		end else begin
			r = CNUM_W'(n);
		end
		return r;
	endfunction

	// A group size of zero acts as one, above nine as nine
	function automatic logic [3:0] eff_group(input logic [3:0] g);
		logic [3:0] r;
		if (g == 4'd0) begin
			r = 4'd1;
		end else if (32'(g) > MAX_GROUP) begin
			r = 4'(MAX_GROUP);
		end else begin
			r = g;
		end
		return r;
	endfunction

endpackage

FILE: sv/mbei_if.sv
// Valid/ready channel interfaces for input and result beats.
interface mbei_in_if;
	import mbei_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mbei_out_if;
	import mbei_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/mbei_front.sv
// Front end: accepts input beats into a short queue ahead of the bit engine.
module mbei_front (
	input  logic               clk,
	input  logic               arst_n,
	mbei_in_if.sink            din,
	output logic               q_valid,
	output mbei_pkg::in_item_t q_data,
	input  logic               q_pop
);
	import mbei_pkg::*;

	in_item_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QFILL_W-1:0] fill_q;
	logic               push;
	logic               pop;

	assign din.ready = (fill_q != QFILL_W'(QUEUE_DEPTH));
	assign push      = din.valid && din.ready;
	assign q_valid   = (fill_q != '0);
	assign pop       = q_pop && q_valid;
	assign q_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + QFILL_W'(1);
				2'b01:   fill_q <= fill_q - QFILL_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

FILE: sv/mbei_engine.sv
// Back end: bit-serial error injection, carrier phases, frame timing and repacking.
module mbei_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  mbei_pkg::cfg_t     cfg,
	input  logic               q_valid,
	input  mbei_pkg::in_item_t q_data,
	output logic               q_pop,
	mbei_out_if.source         dout
);
	import mbei_pkg::*;

	eng_state_t         state_q;
	eng_state_t         state_d;

	logic [15:0]        bitbuf_q;
	logic [15:0]        noisebuf_q;
	logic [4:0]         cnt_q;
	logic [CIDX_W-1:0]  cidx_q;
	logic [FRAME_W-1:0] ft_q;
	phase_t             phase_q [MAX_CARRIERS];
	logic [7:0]         oshift_q;
	logic [2:0]         ocnt_q;
	logic [3:0]         fcnt_q;
	logic [3:0]         bits_left_q;
	logic [START_W-1:0] start_q;
	logic               burst_q;
	logic               pend_valid_q;
	logic [7:0]         pend_byte_q;
	logic [3:0]         pend_flips_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic [CNUM_W-1:0]  n_eff;
	logic [3:0]         g_eff;
	logic [3:0]         pos;
	logic               flip;
	logic               obit;
	logic               byte_done;
	logic [7:0]         new_byte;
	logic [3:0]         new_flips;
	logic               slot_free;
	logic               bit_go;
	logic               group_end;
	logic               check_ok;
	logic               done_go;
	logic               push;
	out_item_t          push_item;
	phase_t             ph_cur;
	phase_t             ph_new;
	logic [END_W-1:0]   t_ext;
	logic [END_W-1:0]   end_ext;
	logic [CNUM_W-1:0]  cnext;
	logic [FRAME_W-1:0] ft_next;

	assign n_eff     = eff_carriers(cfg.carriers_in_use);
	assign g_eff     = eff_group(cfg.group_bits);
	assign pos       = 4'(cnt_q - 5'd1);
	assign flip      = burst_q && noisebuf_q[pos];
	assign obit      = bitbuf_q[pos] ^ flip;
	assign byte_done = (ocnt_q == 3'd7);
	assign new_byte  = {oshift_q[6:0], obit};
	assign new_flips = fcnt_q + 4'(flip);
	assign slot_free = !out_valid_q || dout.ready;
	assign group_end = (bits_left_q == 4'd1);
	assign check_ok  = (cnt_q >= {1'b0, g_eff});
	assign cnext     = {1'b0, cidx_q} + CNUM_W'(1);
	assign ft_next   = ft_q + FRAME_W'(1);

	// Phase step of the carrier about to be served
	assign ph_cur  = phase_q[cidx_q];
	assign t_ext   = END_W'(ft_q);
	assign end_ext = END_W'(start_q) + END_W'(cfg.burst_length_frames);
	always_comb begin
		case (ph_cur)
			PH_CLEAR: ph_new = (t_ext > END_W'(start_q)) ? PH_BURST : PH_CLEAR;
			PH_BURST: ph_new = (t_ext > end_ext) ? PH_DONE : PH_BURST;
			default:  ph_new = ph_cur;
		endcase
	end

	// Next state and control
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		bit_go    = 1'b0;
		done_go   = 1'b0;
		push      = 1'b0;
		push_item = '{out_byte: pend_byte_q, flipped_bits: pend_flips_q, last: 1'b0};
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = check_ok ? ST_PHASE : ST_DONE;
			end
			ST_PHASE: begin
				state_d = ST_BIT;
			end
			ST_BIT: begin
				// stall while a completed byte waits on a full output slot
				if (!(byte_done && pend_valid_q && !slot_free)) begin
					bit_go = 1'b1;
					push   = byte_done && pend_valid_q;
					if (group_end) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_DONE: begin
				if (!pend_valid_q || slot_free) begin
					done_go        = 1'b1;
					push           = pend_valid_q;
					push_item.last = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitbuf_q     <= '0;
			noisebuf_q   <= '0;
			cnt_q        <= '0;
			cidx_q       <= '0;
			ft_q         <= '0;
			for (int i = 0; i < MAX_CARRIERS; i++) begin
				phase_q[i] <= PH_CLEAR;
			end
			oshift_q     <= '0;
			ocnt_q       <= '0;
			fcnt_q       <= '0;
			bits_left_q  <= '0;
			start_q      <= '0;
			burst_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_byte_q  <= '0;
			pend_flips_q <= '0;
		end else begin
			if (q_pop) begin
				bitbuf_q   <= {bitbuf_q[7:0], q_data.in_byte};
				noisebuf_q <= {noisebuf_q[7:0], q_data.noise_mask};
				cnt_q      <= cnt_q + 5'd8;
			end
			if (state_q == ST_CHECK && check_ok) begin
				start_q     <= START_W'(cfg.burst_offset_frames * cnext);
				bits_left_q <= g_eff;
			end
			if (state_q == ST_PHASE) begin
				phase_q[cidx_q] <= ph_new;
				burst_q         <= (ph_new == PH_BURST);
			end
			if (bit_go) begin
				cnt_q       <= cnt_q - 5'd1;
				bits_left_q <= bits_left_q - 4'd1;
				oshift_q    <= new_byte;
				ocnt_q      <= ocnt_q + 3'd1;
				if (byte_done) begin
					fcnt_q       <= '0;
					pend_valid_q <= 1'b1;
					pend_byte_q  <= new_byte;
					pend_flips_q <= new_flips;
				end else begin
					fcnt_q <= new_flips;
				end
				if (group_end) begin
					if (cnext >= n_eff) begin
						cidx_q <= '0;
						if (ft_next > FRAME_W'(cfg.burst_period_frames)) begin
							ft_q <= '0;
							for (int i = 0; i < MAX_CARRIERS; i++) begin
								phase_q[i] <= PH_CLEAR;
							end
						end else begin
							ft_q <= ft_next;
						end
					end else begin
						cidx_q <= CIDX_W'(cnext);
					end
				end
			end
			if (done_go) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Output register parts the engine from the result sink
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= push_item;
		end
	end

	assign dout.valid = out_valid_q;
	assign dout.data  = out_q;

endmodule

FILE: sv/multicarrier_burst_error_injector.sv
// Top level: configuration registers, front queue and bit-serial engine.
// The engine takes one item at a time. For each group it completes (8 over g, give or
// take one, g being the effective group size) it runs a check, a phase step and g bit
// steps, then ends the item with a check and a done step. One bit a cycle, unless a
// finished byte held on a busy output stalls the engine; results leave through a register.
// Reset: arst_n clears the control state at once, configuration returns to 14, 2, 50, 5, 1.
module multicarrier_burst_error_injector (
	input  logic                               clk,
	input  logic                               arst_n,
	mbei_in_if.sink                            din,
	mbei_out_if.source                         dout,
	input  logic                               cfg_we,
	input  logic [mbei_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mbei_pkg::REG_W-1:0]         cfg_wdata
);
	import mbei_pkg::*;

	cfg_t     cfg_q;
	logic     q_valid;
	in_item_t q_data;
	logic     q_pop;

	// Register file: writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.carriers_in_use     <= 5'd14;
			cfg_q.group_bits          <= 4'd2;
			cfg_q.burst_period_frames <= 16'd50;
			cfg_q.burst_length_frames <= 16'd5;
			cfg_q.burst_offset_frames <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CARRIERS: cfg_q.carriers_in_use     <= cfg_wdata[4:0];
				CFG_GROUP:    cfg_q.group_bits          <= cfg_wdata[3:0];
				CFG_PERIOD:   cfg_q.burst_period_frames <= cfg_wdata;
				CFG_LENGTH:   cfg_q.burst_length_frames <= cfg_wdata;
				CFG_OFFSET:   cfg_q.burst_offset_frames <= cfg_wdata;
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	// Front: hold incoming beats until the engine is free
	mbei_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (din),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop)
	);

	// Back: step phases, flip bits in burst, repack into result beats
	mbei_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.dout    (dout)
	);

	// Engine only takes an item that the queue holds
	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("engine popped an empty queue");

	// A result beat never claims more flips than it has bits
	a_flips_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> (dout.data.flipped_bits <= 4'd8))
		else $error("flip count exceeds byte width");

	// A carrier count write takes effect on the next edge
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == CFG_CARRIERS) |=>
		(cfg_q.carriers_in_use == $past(cfg_wdata[4:0])))
		else $error("carrier count write lost");

endmodule

FILE: bench/mbei_flip_checker.sv
// Checker: watches both channels, predicts each result beat and compares it.
`timescale 1ns / 1ps

module mbei_flip_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	mbei_in_if                             din,
	mbei_out_if                            dout,
	input  logic                           cfg_we,
	input  logic [mbei_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mbei_pkg::REG_W-1:0]     cfg_wdata,
	output int                             mismatches,
	output int                             outstanding,
	output int                             results_compared
);
	import mbei_pkg::*;

	// register copies
	logic [4:0]       carriers_reg;
	logic [3:0]       group_reg;
	logic [REG_W-1:0] period_reg;
	logic [REG_W-1:0] length_reg;
	logic [REG_W-1:0] offset_reg;

	// predictor state
	logic [15:0]        data_window;
	logic [15:0]        noise_window;
	logic [4:0]         window_fill;
	logic [CIDX_W-1:0]  carrier_ptr;
	logic [FRAME_W-1:0] frame_count;
	phase_t             carrier_state [MAX_CARRIERS];
	logic [7:0]         pack_shift;
	logic [3:0]         pack_fill;
	logic [3:0]         flip_tally;

	out_item_t injected_bytes [$];
	out_item_t want;
	out_item_t got;

	task automatic report_mismatch(input string what, input int unsigned exp_val,
			input int unsigned got_val);
		$display("mismatch at result %0d: %s expected %0h got %0h",
			results_compared, what, exp_val, got_val);
		mismatches++;
	endtask

	// Push the bytes that one input beat completes, in order.
	task automatic inject_byte(input in_item_t item);
		int unsigned      n_carr;
		int unsigned      grp;
		int unsigned      k;
		int               made;
		logic [END_W-1:0] burst_start;
		logic [END_W-1:0] burst_end;
		logic [CIDX_W-1:0] c;
		logic             hit;
		logic             dbit;
		out_item_t        fresh [2];

		made = 0;
		n_carr = (carriers_reg == 5'd0) ? 1 :
			((carriers_reg > MAX_CARRIERS) ? MAX_CARRIERS : carriers_reg);
		grp = (group_reg == 4'd0) ? 1 : ((group_reg > 4'd9) ? 9 : group_reg);

		data_window = {data_window[7:0], item.in_byte};
		noise_window = {noise_window[7:0], item.noise_mask};
		window_fill = window_fill + 5'd8;

		while (window_fill >= grp) begin
			c = carrier_ptr;
			burst_start = END_W'(offset_reg) * (END_W'(c) + END_W'(1));
			burst_end = burst_start + END_W'(length_reg);
			// step the carrier's phase once before its group
			case (carrier_state[c])
			PH_CLEAR: begin
				if (END_W'(frame_count) > burst_start) carrier_state[c] = PH_BURST;
			end
			PH_BURST: begin
				if (END_W'(frame_count) > burst_end) carrier_state[c] = PH_DONE;
			end
			default: ;
			endcase
			hit = (carrier_state[c] == PH_BURST);

			for (k = 0; k < grp; k++) begin
				window_fill = window_fill - 5'd1;
				dbit = data_window[window_fill];
				if (hit && noise_window[window_fill]) begin
					dbit = ~dbit;
					flip_tally = flip_tally + 4'd1;
				end
				pack_shift = {pack_shift[6:0], dbit};
				pack_fill = pack_fill + 4'd1;
				if (pack_fill == 4'd8) begin
					if (made < 2) begin
						fresh[made] = '{out_byte: pack_shift, flipped_bits: flip_tally,
							last: 1'b0};
						made++;
					end
					pack_shift = '0;
					pack_fill = '0;
					flip_tally = '0;
				end
			end

			// end the frame after the last carrier, also when the count dropped
			if (32'(c) + 1 >= n_carr) begin
				carrier_ptr = '0;
				frame_count = frame_count + 1'b1;
				if (frame_count > FRAME_W'(period_reg)) begin
					frame_count = '0;
					foreach (carrier_state[j]) carrier_state[j] = PH_CLEAR;
				end
			end else begin
				carrier_ptr = c + 1'b1;
			end
		end

		for (int i = 0; i < made; i++) begin
			if (i == made - 1) fresh[i].last = 1'b1;
			injected_bytes.push_back(fresh[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carriers_reg = 5'd14;
			group_reg = 4'd2;
			period_reg = 16'd50;
			length_reg = 16'd5;
			offset_reg = 16'd1;
			data_window = '0;
			noise_window = '0;
			window_fill = '0;
			carrier_ptr = '0;
			frame_count = '0;
			foreach (carrier_state[j]) carrier_state[j] = PH_CLEAR;
			pack_shift = '0;
			pack_fill = '0;
			flip_tally = '0;
			injected_bytes.delete();
			mismatches = 0;
			outstanding = 0;
			results_compared = 0;
		end else begin
			if (dout.valid && dout.ready) begin
				got = dout.data;
				if (injected_bytes.size() == 0) begin
					report_mismatch("result beat with nothing expected, byte", 0,
						got.out_byte);
				end else begin
					want = injected_bytes.pop_front();
					if (got.out_byte !== want.out_byte)
						report_mismatch("out_byte", want.out_byte, got.out_byte);
					if (got.flipped_bits !== want.flipped_bits)
						report_mismatch("flipped_bits", want.flipped_bits, got.flipped_bits);
					if (got.last !== want.last)
						report_mismatch("last", want.last, got.last);
					results_compared++;
				end
			end
			if (din.valid && din.ready) inject_byte(din.data);
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
				CFG_CARRIERS: carriers_reg = cfg_wdata[4:0];
				CFG_GROUP:    group_reg = cfg_wdata[3:0];
				CFG_PERIOD:   period_reg = cfg_wdata;
				CFG_LENGTH:   length_reg = cfg_wdata;
				CFG_OFFSET:   offset_reg = cfg_wdata;
				default: ;
				endcase
			end
			outstanding = injected_bytes.size();
		end
	end

endmodule

FILE: bench/multicarrier_burst_error_injector_tb.sv
// Testbench top: drives input beats and register writes, gives the verdict.
`timescale 1ns / 1ps

module multicarrier_burst_error_injector_tb;
	import mbei_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 5;
	// phases after the directed part, each with its own register setting
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 113;
	// worst item: eight groups of one bit, plus queue depth
	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_CYCLES   = 400;
	localparam int LIMIT_CYCLES  = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_wdata;

	mbei_in_if  din_if ();
	mbei_out_if dout_if ();

	int mismatches;
	int outstanding;
	int results_compared;

	int src_idle_pct;
	int sink_idle_pct;
	int hold_asked;
	int hold_given;
	int hold_left;
	int beats_sent;
	int cycle_count;

	// fixed settings: top extremes, all zero, oversized counts, a count lowered
	// below the running carrier index, bursts on a single carrier that only the period ends
	cfg_t fixed_settings [5] = '{
		'{5'd16, 4'd9, 16'hFFFF, 16'hFFFF, 16'hFFFF},
		'{5'd0, 4'd0, 16'd0, 16'd0, 16'd0},
		'{5'd31, 4'd15, 16'd3, 16'd0, 16'd0},
		'{5'd3, 4'd1, 16'd20, 16'd2, 16'd1},
		'{5'd1, 4'd8, 16'd10, 16'hFFFF, 16'd0}
	};

	always #(CLK_PERIOD / 2) clk = ~clk;

	multicarrier_burst_error_injector u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din_if),
		.dout      (dout_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	mbei_flip_checker u_chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.din              (din_if),
		.dout             (dout_if),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.mismatches       (mismatches),
		.outstanding      (outstanding),
		.results_compared (results_compared)
	);

	// Receiver: random back-pressure, or a long hold-off when one is asked for.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			dout_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asked != hold_given) begin
			hold_given <= hold_asked;
			hold_left <= HOLD_CYCLES;
			dout_if.ready <= 1'b0;
		end else begin
			dout_if.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
			$display("tb: failure");
			$finish;
		end
	end

	// Offer one beat, idling first at the sender's rate; return at the falling
	// edge after the beat has gone, with valid still high.
	task automatic send_beat(input logic [7:0] data, input logic [7:0] noise);
		while ($urandom_range(99) < src_idle_pct) begin
			din_if.valid <= 1'b0;
			@(negedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.data <= '{in_byte: data, noise_mask: noise};
		@(posedge clk);
		while (!din_if.ready) @(posedge clk);
		beats_sent++;
		@(negedge clk);
	endtask

	// Drop valid, wait for every expected beat, then let any result-less item
	// still in the engine run out.
	task automatic drain_block();
		din_if.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register write per falling edge; the caller lowers the enable.
	task automatic write_reg(input cfg_idx_t idx, input logic [REG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
	endtask

	initial begin
		cfg_t             setting;
		logic [REG_W-1:0] junk;
		int               p;
		int               k;
		int               r;
		logic [7:0]       noise;

		arst_n = 1'b0;
		din_if.valid = 1'b0;
		din_if.data = '0;
		dout_if.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_CARRIERS;
		cfg_wdata = '0;
		src_idle_pct = 22;
		sink_idle_pct = 65;
		hold_asked = 0;
		hold_given = 0;
		hold_left = 0;
		beats_sent = 0;
		cycle_count = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset setting: field extremes, alternating
		// patterns, then enough all-flip noise to walk carriers into burst.
		send_beat(8'h00, 8'h00);
		send_beat(8'hFF, 8'h00);
		send_beat(8'h00, 8'hFF);
		send_beat(8'hFF, 8'hFF);
		send_beat(8'hAA, 8'h55);
		send_beat(8'h55, 8'hAA);
		send_beat(8'h80, 8'h01);
		send_beat(8'h01, 8'h80);
		for (k = 0; k < 4; k++) send_beat(8'hFF, 8'hFF);
		for (k = 0; k < 4; k++) send_beat(8'h00, 8'hFF);
		send_beat(8'hA5, 8'hF0);
		send_beat(8'h5A, 8'h0F);
		send_beat(8'h3C, 8'hC3);
		send_beat(8'hC3, 8'h3C);

		for (p = 1; p <= PHASES; p++) begin
			drain_block();

			if (p <= 5) begin
				setting = fixed_settings[p - 1];
				junk = '0;
			end else begin
				// mostly small timings so bursts start and end within a phase
				setting.carriers_in_use = ($urandom_range(9) == 0) ?
					5'($urandom_range(31)) : 5'($urandom_range(1, 16));
				setting.group_bits = ($urandom_range(9) == 0) ?
					4'($urandom_range(15)) : 4'($urandom_range(1, 9));
				setting.burst_period_frames = ($urandom_range(7) == 0) ?
					16'($urandom) : 16'($urandom_range(0, 60));
				setting.burst_length_frames = ($urandom_range(7) == 0) ?
					16'($urandom) : 16'($urandom_range(0, 12));
				setting.burst_offset_frames = ($urandom_range(7) == 0) ?
					16'($urandom) : 16'($urandom_range(0, 6));
				// stray upper bits on the narrow registers must be dropped
				junk = 16'($urandom);
			end
			write_reg(CFG_CARRIERS, {junk[15:5], setting.carriers_in_use});
			write_reg(CFG_GROUP, {junk[15:4], setting.group_bits});
			write_reg(CFG_PERIOD, setting.burst_period_frames);
			write_reg(CFG_LENGTH, setting.burst_length_frames);
			write_reg(CFG_OFFSET, setting.burst_offset_frames);
			cfg_we <= 1'b0;

			// sender light and receiver heavy, then swapped, then no idling
			src_idle_pct = (p <= 3) ? 22 : ((p <= 6) ? 65 : 0);
			sink_idle_pct <= (p <= 3) ? 65 : ((p <= 6) ? 22 : 0);
			// long receiver hold-off while the sender keeps offering
			if (p == 7) hold_asked <= hold_asked + 1;

			for (k = 0; k < PHASE_ITEMS; k++) begin
				// once, pause the sender until every due result is out
				if (p == 5 && k == PHASE_ITEMS / 2) begin
					din_if.valid <= 1'b0;
					@(negedge clk);
					while (outstanding != 0) @(negedge clk);
				end
				r = $urandom_range(99);
				noise = (r < 25) ? 8'hFF : ((r < 40) ? 8'h00 : 8'($urandom));
				send_beat(8'($urandom), noise);
			end
		end

		drain_block();

		$display("covered %0d input beats over %0d register settings, %0d result beats compared",
			beats_sent, PHASES + 1, results_compared);
		$display("settings included zero and oversized counts, one-frame periods and full-scale timing");
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/mbei_pkg.sv
sv/mbei_if.sv
sv/mbei_front.sv
sv/mbei_engine.sv
sv/multicarrier_burst_error_injector.sv
bench/mbei_flip_checker.sv
bench/multicarrier_burst_error_injector_tb.sv
